// File: rtl/core/rau_pkg.sv
package rau_pkg;

    localparam int WORD_WIDTH = 64;
    localparam int DCNT_W = $clog2(WORD_WIDTH);
    localparam int PC_W = 7;
    localparam int REG_N = 16;

    typedef logic [3:0] t_reg;
    typedef logic [3:0] t_act;
    typedef logic [3:0] t_cond;
    typedef logic [PC_W-1:0] t_pc;
    typedef logic [WORD_WIDTH-1:0] t_word;

    localparam t_reg REG_AN = 4'd0;
    localparam t_reg REG_AD = 4'd1;
    localparam t_reg REG_BN = 4'd2;
    localparam t_reg REG_BD = 4'd3;
    localparam t_reg REG_X  = 4'd4;
    localparam t_reg REG_Y  = 4'd5;
    localparam t_reg REG_Q  = 4'd6;
    localparam t_reg REG_R  = 4'd7;
    localparam t_reg REG_P  = 4'd8;
    localparam t_reg REG_G  = 4'd9;
    localparam t_reg REG_T1 = 4'd10;
    localparam t_reg REG_T2 = 4'd11;
    localparam t_reg REG_T3 = 4'd12;
    localparam t_reg REG_RN = 4'd13;
    localparam t_reg REG_RD = 4'd14;
    localparam t_reg REG_SP = 4'd15;

    localparam t_act A_NONE    = 4'd0;
    localparam t_act A_DIV     = 4'd1;
    localparam t_act A_MUL     = 4'd2;
    localparam t_act A_ADD     = 4'd3;
    localparam t_act A_SIGNA   = 4'd4;
    localparam t_act A_SMUL    = 4'd5;
    localparam t_act A_DIVZ    = 4'd6;
    localparam t_act A_CMPPRE  = 4'd7;
    localparam t_act A_CMPSTEP = 4'd8;
    localparam t_act A_END     = 4'd9;

    localparam t_cond C_NEXT    = 4'd0;
    localparam t_cond C_ALWAYS  = 4'd1;
    localparam t_cond C_ERR     = 4'd2;
    localparam t_cond C_MAKE    = 4'd3;
    localparam t_cond C_ADDSUB  = 4'd4;
    localparam t_cond C_MUL     = 4'd5;
    localparam t_cond C_DIV     = 4'd6;
    localparam t_cond C_CMPDONE = 4'd7;
    localparam t_cond C_BNZERO  = 4'd8;
    localparam t_cond C_OVF     = 4'd9;
    localparam t_cond C_YZERO   = 4'd10;

    localparam logic [2:0] MODE_MAKE = 3'd0;
    localparam logic [2:0] MODE_ADD  = 3'd1;
    localparam logic [2:0] MODE_SUB  = 3'd2;
    localparam logic [2:0] MODE_MUL  = 3'd3;
    localparam logic [2:0] MODE_DIV  = 3'd4;
    localparam logic [2:0] MODE_CMP  = 3'd5;

    localparam logic [2:0] STAT_OK    = 3'd0;
    localparam logic [2:0] STAT_ZDEN  = 3'd1;
    localparam logic [2:0] STAT_RANGE = 3'd2;
    localparam logic [2:0] STAT_OVF   = 3'd3;
    localparam logic [2:0] STAT_DIVZ  = 3'd4;

    localparam logic [1:0] ORD_LESS    = 2'd0;
    localparam logic [1:0] ORD_EQUAL   = 2'd1;
    localparam logic [1:0] ORD_GREATER = 2'd2;

    localparam t_pc L_CMPLOOP = 7'd17;
    localparam t_pc L_MK      = 7'd31;
    localparam t_pc L_ADD     = 7'd33;
    localparam t_pc L_DV      = 7'd59;
    localparam t_pc L_MU      = 7'd63;
    localparam t_pc L_FR      = 7'd93;
    localparam t_pc L_FIN     = 7'd95;
    localparam t_pc L_GCD     = 7'd96;
    localparam t_pc L_GRET    = 7'd100;
    localparam t_pc L_RED     = 7'd101;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [63:0] a_num;
        logic signed [63:0] a_den;
        logic signed [63:0] b_num;
        logic signed [63:0] b_den;
    } t_in;

    typedef struct packed {
        logic signed [63:0] res_num;
        logic [62:0]        res_den;
        logic [1:0]         order;
        logic [2:0]         status;
    } t_out;

    typedef struct packed {
        logic  mv_en;
        t_reg  dst;
        t_reg  src;
        t_act  act;
        t_cond cond;
        logic  call;
        logic  ret;
        t_pc   target;
    } t_uinst;

    typedef struct packed {
        logic load;
        logic mv_en;
        t_reg dst;
        t_reg src;
        t_act act;
    } t_cmd;

    typedef struct packed {
        logic err;
        logic mode_make;
        logic mode_addsub;
        logic mode_mul;
        logic mode_div;
        logic cmp_done;
        logic bn_zero;
        logic ovf;
        logic y_zero;
        logic unit_done;
    } t_stat;

    function automatic t_uinst mv(input t_reg d, input t_reg s);
        t_uinst u;
        u = '0;
        u.mv_en = 1'b1;
        u.dst = d;
        u.src = s;
        return u;
    endfunction

    function automatic t_uinst mvj(input t_reg d, input t_reg s, input t_pc t);
        t_uinst u;
        u = mv(d, s);
        u.cond = C_ALWAYS;
        u.target = t;
        return u;
    endfunction

    function automatic t_uinst mva(input t_reg d, input t_reg s, input t_act a);
        t_uinst u;
        u = mv(d, s);
        u.act = a;
        return u;
    endfunction

    function automatic t_uinst op(input t_act a);
        t_uinst u;
        u = '0;
        u.act = a;
        return u;
    endfunction

    function automatic t_uinst br(input t_cond c, input t_pc t);
        t_uinst u;
        u = '0;
        u.cond = c;
        u.target = t;
        return u;
    endfunction

    function automatic t_uinst call(input t_pc t);
        t_uinst u;
        u = '0;
        u.call = 1'b1;
        u.target = t;
        return u;
    endfunction

    function automatic t_uinst ret_op();
        t_uinst u;
        u = '0;
        u.ret = 1'b1;
        return u;
    endfunction

    function automatic t_uinst ucode(input t_pc pc);
        t_uinst u;
        u = op(A_END);
        case (pc)
            0:   u = br(C_ERR, L_FIN);
            1:   u = mv(REG_RN, REG_AN);
            2:   u = mv(REG_RD, REG_AD);
            3:   u = call(L_RED);
            4:   u = mv(REG_AN, REG_RN);
            5:   u = mv(REG_AD, REG_RD);
            6:   u = br(C_MAKE, L_MK);
            7:   u = mv(REG_RN, REG_BN);
            8:   u = mv(REG_RD, REG_BD);
            9:   u = call(L_RED);
            10:  u = mv(REG_BN, REG_RN);
            11:  u = mv(REG_BD, REG_RD);
            12:  u = br(C_ADDSUB, L_ADD);
            13:  u = br(C_MUL, L_MU);
            14:  u = br(C_DIV, L_DV);
            15:  u = op(A_CMPPRE);
            16:  u = br(C_CMPDONE, L_FIN);
            17:  u = mv(REG_X, REG_AN);
            18:  u = mv(REG_Y, REG_AD);
            19:  u = op(A_DIV);
            20:  u = mv(REG_T1, REG_Q);
            21:  u = mv(REG_T2, REG_R);
            22:  u = mv(REG_X, REG_BN);
            23:  u = mv(REG_Y, REG_BD);
            24:  u = op(A_DIV);
            25:  u = op(A_CMPSTEP);
            26:  u = br(C_CMPDONE, L_FIN);
            27:  u = mv(REG_AN, REG_BD);
            28:  u = mv(REG_BN, REG_AD);
            29:  u = mv(REG_AD, REG_R);
            30:  u = mvj(REG_BD, REG_T2, L_CMPLOOP);
            31:  u = mva(REG_RN, REG_AN, A_SIGNA);
            32:  u = mvj(REG_RD, REG_AD, L_FIN);
            33:  u = mv(REG_X, REG_AD);
            34:  u = mv(REG_Y, REG_BD);
            35:  u = call(L_GCD);
            36:  u = mv(REG_G, REG_X);
            37:  u = mv(REG_X, REG_AD);
            38:  u = mv(REG_Y, REG_G);
            39:  u = op(A_DIV);
            40:  u = mv(REG_T1, REG_Q);
            41:  u = mv(REG_X, REG_BD);
            42:  u = op(A_DIV);
            43:  u = mv(REG_T2, REG_Q);
            44:  u = mv(REG_X, REG_AN);
            45:  u = mv(REG_Y, REG_T2);
            46:  u = op(A_MUL);
            47:  u = mv(REG_T3, REG_P);
            48:  u = mv(REG_X, REG_BN);
            49:  u = mv(REG_Y, REG_T1);
            50:  u = op(A_MUL);
            51:  u = mv(REG_Y, REG_P);
            52:  u = mv(REG_X, REG_T3);
            53:  u = op(A_ADD);
            54:  u = mv(REG_RN, REG_P);
            55:  u = mv(REG_X, REG_T1);
            56:  u = mv(REG_Y, REG_BD);
            57:  u = op(A_MUL);
            58:  u = mvj(REG_RD, REG_P, L_FR);
            59:  begin
                u = br(C_BNZERO, L_FIN);
                u.act = A_DIVZ;
            end
            60:  u = mv(REG_T1, REG_BN);
            61:  u = mv(REG_BN, REG_BD);
            62:  u = mv(REG_BD, REG_T1);
            63:  u = mv(REG_X, REG_AN);
            64:  u = mv(REG_Y, REG_BD);
            65:  u = call(L_GCD);
            66:  u = mv(REG_G, REG_X);
            67:  u = mv(REG_X, REG_BN);
            68:  u = mv(REG_Y, REG_AD);
            69:  u = call(L_GCD);
            70:  u = mv(REG_T1, REG_X);
            71:  u = mv(REG_X, REG_AN);
            72:  u = mv(REG_Y, REG_G);
            73:  u = op(A_DIV);
            74:  u = mv(REG_T2, REG_Q);
            75:  u = mv(REG_X, REG_BN);
            76:  u = mv(REG_Y, REG_T1);
            77:  u = op(A_DIV);
            78:  u = mv(REG_Y, REG_Q);
            79:  u = mv(REG_X, REG_T2);
            80:  u = op(A_MUL);
            81:  u = mv(REG_RN, REG_P);
            82:  u = mv(REG_X, REG_AD);
            83:  u = mv(REG_Y, REG_T1);
            84:  u = op(A_DIV);
            85:  u = mv(REG_T2, REG_Q);
            86:  u = mv(REG_X, REG_BD);
            87:  u = mv(REG_Y, REG_G);
            88:  u = op(A_DIV);
            89:  u = mv(REG_Y, REG_Q);
            90:  u = mv(REG_X, REG_T2);
            91:  u = op(A_MUL);
            92:  begin
                u = mvj(REG_RD, REG_P, L_FR);
                u.act = A_SMUL;
            end
            93:  u = br(C_OVF, L_FIN);
            94:  u = call(L_RED);
            95:  u = op(A_END);
            96:  u = br(C_YZERO, L_GRET);
            97:  u = op(A_DIV);
            98:  u = mv(REG_X, REG_Y);
            99:  u = mvj(REG_Y, REG_R, L_GCD);
            100: u = ret_op();
            101: u = mv(REG_X, REG_RN);
            102: u = mv(REG_Y, REG_RD);
            103: u = call(L_GCD);
            104: u = mv(REG_G, REG_X);
            105: u = mv(REG_X, REG_RN);
            106: u = mv(REG_Y, REG_G);
            107: u = op(A_DIV);
            108: u = mv(REG_RN, REG_Q);
            109: u = mv(REG_X, REG_RD);
            110: u = op(A_DIV);
            111: u = mv(REG_RD, REG_Q);
            112: u = ret_op();
            default: u = op(A_END);
        endcase
        return u;
    endfunction

endpackage

// File: rtl/core/rau_divider.sv
module rau_divider
    import rau_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_word i_dividend,
    input  t_word i_divisor,
    output logic  o_done,
    output t_word o_quo,
    output t_word o_rem
);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [DCNT_W-1:0] r_cnt, n_cnt;
    t_word             r_q, n_q;
    t_word             r_r, n_r;
    t_word             r_d, n_d;
    logic [WORD_WIDTH:0] trial;

    always_comb begin
        trial = {r_r, r_q[WORD_WIDTH-1]} - {1'b0, r_d};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt = r_cnt;
        n_q = r_q;
        n_r = r_r;
        n_d = r_d;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt = '0;
            n_q = i_dividend;
            n_r = '0;
            n_d = i_divisor;
        end else if (r_busy) begin
            if (!trial[WORD_WIDTH]) begin
                n_r = trial[WORD_WIDTH-1:0];
                n_q = {r_q[WORD_WIDTH-2:0], 1'b1};
            end else begin
                n_r = {r_r[WORD_WIDTH-2:0], r_q[WORD_WIDTH-1]};
                n_q = {r_q[WORD_WIDTH-2:0], 1'b0};
            end
            n_cnt = r_cnt + DCNT_W'(1);
            if (r_cnt == DCNT_W'(WORD_WIDTH - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt <= n_cnt;
        end
        r_q <= n_q;
        r_r <= n_r;
        r_d <= n_d;
    end

    assign o_done = r_done;
    assign o_quo = r_q;
    assign o_rem = r_r;

endmodule

// File: rtl/core/rau_multiplier.sv
module rau_multiplier
    import rau_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_word i_x,
    input  t_word i_y,
    output logic  o_done,
    output t_word o_prod,
    output logic  o_ovf
);

    logic                      r_busy, n_busy;
    logic                      r_done, n_done;
    logic [DCNT_W-1:0]         r_cnt, n_cnt;
    logic [2*WORD_WIDTH-1:0]   r_acc, n_acc;
    t_word                     r_x, n_x;
    logic [WORD_WIDTH:0]       sum;

    always_comb begin
        sum = {1'b0, r_acc[2*WORD_WIDTH-1:WORD_WIDTH]}
            + (r_acc[0] ? {1'b0, r_x} : '0);
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt = r_cnt;
        n_acc = r_acc;
        n_x = r_x;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt = '0;
            n_acc = {{WORD_WIDTH{1'b0}}, i_y};
            n_x = i_x;
        end else if (r_busy) begin
            n_acc = {sum, r_acc[WORD_WIDTH-1:1]};
            n_cnt = r_cnt + DCNT_W'(1);
            if (r_cnt == DCNT_W'(WORD_WIDTH - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt <= n_cnt;
        end
        r_acc <= n_acc;
        r_x <= n_x;
    end

    assign o_done = r_done;
    assign o_prod = r_acc[WORD_WIDTH-1:0];
    assign o_ovf = |r_acc[2*WORD_WIDTH-1:WORD_WIDTH-1];

endmodule

// File: rtl/core/rau_datapath.sv
module rau_datapath
    import rau_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_in   i_op,
    input  t_cmd  i_cmd,
    output t_stat o_stat,
    output t_out  o_res
);

    t_word      r_rf [REG_N];
    logic [2:0] r_mode;
    logic [2:0] r_err;
    logic       r_sa, r_sb, r_sr;
    logic       r_ovf, r_divz, r_cmp_done, r_flip;
    logic [1:0] r_order;

    logic       div_done, mul_done, mul_ovf;
    t_word      quo, rem, prod;

    t_word a_n, a_d, b_n, b_d;
    logic  a_zd, a_rg, b_zd, b_rg, use_b;
    logic [2:0] err_in;

    logic  add_s2, add_sr, add_ovf;
    logic [WORD_WIDTH:0] add_sum;
    t_word add_res;

    logic       na, nb, eq_all;
    logic [1:0] sx, sy;
    logic [1:0] pre_ord, step_ord;
    logic       pre_done, step_done;

    logic  have, neg;
    t_word num_w;
    logic [2:0] stat;

    function automatic t_word mag(input t_word v);
        return v[WORD_WIDTH-1] ? (~v + t_word'(1)) : v;
    endfunction

    function automatic logic [1:0] flip_ord(input logic [1:0] o, input logic f);
        logic [1:0] res;
        res = o;
        if (f && o == ORD_LESS) begin
            res = ORD_GREATER;
        end else if (f && o == ORD_GREATER) begin
            res = ORD_LESS;
        end
        return res;
    endfunction

    rau_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.act == A_DIV),
        .i_dividend (r_rf[REG_X]),
        .i_divisor  (r_rf[REG_Y]),
        .o_done     (div_done),
        .o_quo      (quo),
        .o_rem      (rem)
    );

    rau_multiplier u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.act == A_MUL),
        .i_x     (r_rf[REG_X]),
        .i_y     (r_rf[REG_Y]),
        .o_done  (mul_done),
        .o_prod  (prod),
        .o_ovf   (mul_ovf)
    );

    always_comb begin
        a_n = i_op.a_num[WORD_WIDTH-1:0];
        a_d = i_op.a_den[WORD_WIDTH-1:0];
        b_n = i_op.b_num[WORD_WIDTH-1:0];
        b_d = i_op.b_den[WORD_WIDTH-1:0];
        a_zd = (a_d == '0);
        a_rg = (a_n == {1'b1, {(WORD_WIDTH-1){1'b0}}})
            || (a_d == {1'b1, {(WORD_WIDTH-1){1'b0}}});
        b_zd = (b_d == '0);
        b_rg = (b_n == {1'b1, {(WORD_WIDTH-1){1'b0}}})
            || (b_d == {1'b1, {(WORD_WIDTH-1){1'b0}}});
        use_b = (i_op.mode inside {[MODE_ADD:MODE_CMP]});
        if (a_zd) begin
            err_in = STAT_ZDEN;
        end else if (a_rg) begin
            err_in = STAT_RANGE;
        end else if (use_b && b_zd) begin
            err_in = STAT_ZDEN;
        end else if (use_b && b_rg) begin
            err_in = STAT_RANGE;
        end else begin
            err_in = STAT_OK;
        end
    end

    always_comb begin
        add_s2 = r_sb ^ (r_mode == MODE_SUB);
        add_sum = {1'b0, r_rf[REG_X]} + {1'b0, r_rf[REG_Y]};
        add_ovf = 1'b0;
        if (r_sa == add_s2) begin
            add_sr = r_sa;
            add_res = add_sum[WORD_WIDTH-1:0];
            add_ovf = add_sum[WORD_WIDTH] | add_sum[WORD_WIDTH-1];
        end else if (r_rf[REG_X] >= r_rf[REG_Y]) begin
            add_sr = r_sa;
            add_res = r_rf[REG_X] - r_rf[REG_Y];
        end else begin
            add_sr = add_s2;
            add_res = r_rf[REG_Y] - r_rf[REG_X];
        end
    end

    always_comb begin
        na = r_sa && (r_rf[REG_AN] != '0);
        nb = r_sb && (r_rf[REG_BN] != '0);
        eq_all = (na == nb) && (r_rf[REG_AN] == r_rf[REG_BN])
            && (r_rf[REG_AD] == r_rf[REG_BD]);
        sx = (r_rf[REG_AN] == '0) ? 2'd1 : (na ? 2'd0 : 2'd2);
        sy = (r_rf[REG_BN] == '0) ? 2'd1 : (nb ? 2'd0 : 2'd2);
        pre_done = 1'b1;
        if (eq_all) begin
            pre_ord = ORD_EQUAL;
        end else if (sx != sy) begin
            pre_ord = (sx < sy) ? ORD_LESS : ORD_GREATER;
        end else if (sx == 2'd1) begin
            pre_ord = ORD_EQUAL;
        end else begin
            pre_ord = ORD_EQUAL;
            pre_done = 1'b0;
        end

        step_done = 1'b1;
        if (r_rf[REG_T1] != r_rf[REG_Q]) begin
            step_ord = (r_rf[REG_T1] < r_rf[REG_Q]) ? ORD_LESS : ORD_GREATER;
        end else if (r_rf[REG_T2] == '0 && r_rf[REG_R] == '0) begin
            step_ord = ORD_EQUAL;
        end else if (r_rf[REG_T2] == '0) begin
            step_ord = ORD_LESS;
        end else if (r_rf[REG_R] == '0) begin
            step_ord = ORD_GREATER;
        end else begin
            step_ord = ORD_EQUAL;
            step_done = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovf <= 1'b0;
            r_divz <= 1'b0;
            r_cmp_done <= 1'b0;
            r_order <= ORD_LESS;
            r_err <= STAT_OK;
        end else if (i_cmd.load) begin
            r_ovf <= 1'b0;
            r_divz <= 1'b0;
            r_cmp_done <= 1'b0;
            r_order <= ORD_LESS;
            r_err <= err_in;
        end else begin
            if (mul_done && mul_ovf) begin
                r_ovf <= 1'b1;
            end
            case (i_cmd.act)
                A_ADD: begin
                    if (add_ovf) begin
                        r_ovf <= 1'b1;
                    end
                end
                A_DIVZ: begin
                    r_divz <= (r_rf[REG_BN] == '0);
                end
                A_CMPPRE: begin
                    r_cmp_done <= pre_done;
                    r_order <= pre_ord;
                end
                A_CMPSTEP: begin
                    r_cmp_done <= step_done;
                    r_order <= flip_ord(step_ord, r_flip);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_op.mode;
            r_rf[REG_AN] <= mag(a_n);
            r_rf[REG_AD] <= mag(a_d);
            r_rf[REG_BN] <= mag(b_n);
            r_rf[REG_BD] <= mag(b_d);
            r_sa <= a_n[WORD_WIDTH-1] ^ a_d[WORD_WIDTH-1];
            r_sb <= b_n[WORD_WIDTH-1] ^ b_d[WORD_WIDTH-1];
            r_sr <= 1'b0;
        end else begin
            if (i_cmd.mv_en) begin
                r_rf[i_cmd.dst] <= r_rf[i_cmd.src];
            end
            if (div_done) begin
                r_rf[REG_Q] <= quo;
                r_rf[REG_R] <= rem;
            end
            if (mul_done) begin
                r_rf[REG_P] <= prod;
            end
            case (i_cmd.act)
                A_ADD: begin
                    r_rf[REG_P] <= add_res;
                    r_sr <= add_sr;
                end
                A_SIGNA: r_sr <= r_sa;
                A_SMUL:  r_sr <= r_sa ^ r_sb;
                A_CMPPRE: r_flip <= (sx == 2'd0);
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_err != STAT_OK) begin
            stat = r_err;
        end else if (r_divz) begin
            stat = STAT_DIVZ;
        end else if (r_ovf) begin
            stat = STAT_OVF;
        end else begin
            stat = STAT_OK;
        end
        have = (stat == STAT_OK) && (r_mode != MODE_CMP);
        neg = r_sr && (r_rf[REG_RN] != '0);
        num_w = neg ? (t_word'(0) - r_rf[REG_RN]) : r_rf[REG_RN];
        o_res.res_num = have ? 64'(signed'(num_w)) : '0;
        o_res.res_den = have ? 63'(r_rf[REG_RD]) : '0;
        o_res.order = (r_mode == MODE_CMP) ? r_order : ORD_LESS;
        o_res.status = stat;
    end

    always_comb begin
        o_stat.err = (r_err != STAT_OK);
        o_stat.mode_make = !(r_mode inside {[MODE_ADD:MODE_CMP]});
        o_stat.mode_addsub = (r_mode == MODE_ADD) || (r_mode == MODE_SUB);
        o_stat.mode_mul = (r_mode == MODE_MUL);
        o_stat.mode_div = (r_mode == MODE_DIV);
        o_stat.cmp_done = r_cmp_done;
        o_stat.bn_zero = (r_rf[REG_BN] == '0);
        o_stat.ovf = r_ovf;
        o_stat.y_zero = (r_rf[REG_Y] == '0);
        o_stat.unit_done = div_done | mul_done;
    end

endmodule

// File: rtl/core/rau_ctrl.sv
module rau_ctrl
    import rau_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  busy,
    output logic  o_valid
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] r_state, n_state;
    t_pc        r_pc, n_pc;
    t_pc        r_ret0, n_ret0;
    t_pc        r_ret1, n_ret1;
    t_uinst     u;
    logic       taken;
    t_pc        pc_inc;

    always_comb begin
        u = ucode(r_pc);
        pc_inc = r_pc + t_pc'(1);
        case (u.cond)
            C_NEXT:    taken = 1'b0;
            C_ALWAYS:  taken = 1'b1;
            C_ERR:     taken = i_stat.err;
            C_MAKE:    taken = i_stat.mode_make;
            C_ADDSUB:  taken = i_stat.mode_addsub;
            C_MUL:     taken = i_stat.mode_mul;
            C_DIV:     taken = i_stat.mode_div;
            C_CMPDONE: taken = i_stat.cmp_done;
            C_BNZERO:  taken = i_stat.bn_zero;
            C_OVF:     taken = i_stat.ovf;
            C_YZERO:   taken = i_stat.y_zero;
            default:   taken = 1'b0;
        endcase

        o_cmd = '0;
        n_state = r_state;
        n_pc = r_pc;
        n_ret0 = r_ret0;
        n_ret1 = r_ret1;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_pc = '0;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.mv_en = u.mv_en;
                o_cmd.dst = u.dst;
                o_cmd.src = u.src;
                o_cmd.act = u.act;
                if (u.act == A_DIV || u.act == A_MUL) begin
                    n_state = S_WAIT;
                end else if (u.act == A_END) begin
                    n_state = S_DONE;
                end else if (u.call) begin
                    n_ret1 = r_ret0;
                    n_ret0 = pc_inc;
                    n_pc = u.target;
                end else if (u.ret) begin
                    n_pc = r_ret0;
                    n_ret0 = r_ret1;
                end else if (taken) begin
                    n_pc = u.target;
                end else begin
                    n_pc = pc_inc;
                end
            end
            S_WAIT: begin
                if (i_stat.unit_done) begin
                    n_pc = pc_inc;
                    n_state = S_EXEC;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc <= '0;
            r_ret0 <= '0;
            r_ret1 <= '0;
        end else begin
            r_state <= n_state;
            r_pc <= n_pc;
            r_ret0 <= n_ret0;
            r_ret1 <= n_ret1;
        end
    end

    assign busy = (r_state != S_IDLE);
    assign o_valid = (r_state == S_DONE);

    a_done_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> (r_state == S_IDLE))
        else $error("Result strobe lasted more than one cycle.");

    a_unit_done_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.unit_done |-> (r_state == S_WAIT))
        else $error("Arithmetic unit finished while the sequencer was not waiting.");

    a_start_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == S_EXEC && r_pc == '0))
        else $error("Accepted word did not start the program at its entry.");

endmodule

// File: rtl/core/rational_arithmetic_unit.sv
// Channel   Direction  Handshake            Payload
// command   in         start high, busy low i_op  (t_in)
// result    out        o_valid, one cycle   o_res (t_out)
//
// One word is worked on at a time; busy stays high from acceptance until the result strobe.
// Each division or product runs on the single shared divider or multiplier while the sequencer waits;
// an operand error branches to the end at the first program step, and other items take longer
// the more division and product steps their GCDs need.
// The synchronous reset returns the sequencer to idle; no word is in flight after it.
// The receiver cannot stall: o_valid is high for exactly one cycle per accepted word.
module rational_arithmetic_unit
    import rau_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_in  i_op,
    output logic busy,
    output logic o_valid,
    output t_out o_res
);

    t_cmd  cmd;
    t_stat stat;

    rau_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy),
        .o_valid (o_valid)
    );

    rau_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (i_op),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_res   (o_res)
    );

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import rau_pkg::*;

    typedef struct {
        logic signed [63:0] num;
        logic [62:0]        den;
        logic [1:0]         order;
        logic [2:0]         status;
    } t_expect;

    localparam logic [63:0] MIN_WORD = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAG_MAX  = 64'h7fff_ffff_ffff_ffff;
    localparam int IDLE_LIMIT = 200000;

    logic i_clk;
    logic i_rst_n;
    logic start;
    t_in  i_op;
    logic busy;
    logic o_valid;
    t_out o_res;

    t_expect expected_q[$];
    int mismatch_count;
    int result_count;
    int sent_count;
    int idle_cycles;
    bit timed_out;

    rational_arithmetic_unit dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .i_op(i_op),
        .busy(busy),
        .o_valid(o_valid),
        .o_res(o_res)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic logic [63:0] gcd_of(input logic [63:0] x, input logic [63:0] y);
        logic [63:0] t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic bit mul_fits(input logic [63:0] x, input logic [63:0] y,
                                    output logic [63:0] p);
        p = x * y;
        return !(x != 0 && y > MAG_MAX / x);
    endfunction

    function automatic void reduce_frac(input bit neg, input logic [63:0] n,
                                        input logic [63:0] d, output bit rneg,
                                        output logic [63:0] rn, output logic [63:0] rd);
        logic [63:0] g;
        g = gcd_of(n, d);
        rn = n / g;
        rd = d / g;
        rneg = neg && rn != 0;
    endfunction

    function automatic logic [2:0] load_frac(input logic [63:0] num, input logic [63:0] den,
                                             output bit neg, output logic [63:0] n,
                                             output logic [63:0] d);
        logic [63:0] mn;
        logic [63:0] md;
        if (den == 0)
            return STAT_ZDEN;
        if (num == MIN_WORD || den == MIN_WORD)
            return STAT_RANGE;
        mn = num[63] ? -num : num;
        md = den[63] ? -den : den;
        reduce_frac(num[63] != den[63], mn, md, neg, n, d);
        return STAT_OK;
    endfunction

    function automatic int order_pos(input logic [63:0] x, input logic [63:0] y,
                                     input logic [63:0] z, input logic [63:0] w);
        logic [63:0] q1;
        logic [63:0] q2;
        logic [63:0] r1;
        logic [63:0] r2;
        logic [63:0] t;
        forever begin
            q1 = x / y;
            q2 = z / w;
            if (q1 != q2)
                return q1 < q2 ? -1 : 1;
            r1 = x % y;
            r2 = z % w;
            if (r1 == 0 && r2 == 0)
                return 0;
            if (r1 == 0)
                return -1;
            if (r2 == 0)
                return 1;
            t = y;
            x = w;
            y = r2;
            z = t;
            w = r1;
        end
    endfunction

    function automatic t_expect rational_result(input t_in op);
        t_expect e;
        bit an_neg, bn_neg, r_neg, s_neg, bs;
        logic [63:0] an, ad, bn, bd, rn, rd, g, g2, dag, dbg, t1, t2, sm, dn, nn;
        logic [2:0] st;
        int sa, sb, m;
        bit have;
        logic [1:0] ord;
        have = 0;
        ord = ORD_LESS;
        rn = 0;
        rd = 0;
        r_neg = 0;
        st = load_frac(op.a_num, op.a_den, an_neg, an, ad);
        if (st == STAT_OK && op.mode >= MODE_ADD && op.mode <= MODE_CMP)
            st = load_frac(op.b_num, op.b_den, bn_neg, bn, bd);
        if (st == STAT_OK) begin
            case (op.mode)
                MODE_ADD, MODE_SUB: begin
                    g = gcd_of(ad, bd);
                    dag = ad / g;
                    dbg = bd / g;
                    bs = (op.mode == MODE_SUB) ? !bn_neg : bn_neg;
                    if (!mul_fits(an, dbg, t1) || !mul_fits(bn, dag, t2)) begin
                        st = STAT_OVF;
                    end else begin
                        if (an_neg == bs) begin
                            sm = t1 + t2;
                            s_neg = an_neg;
                            if (sm > MAG_MAX || sm < t1)
                                st = STAT_OVF;
                        end else if (t1 >= t2) begin
                            sm = t1 - t2;
                            s_neg = an_neg;
                        end else begin
                            sm = t2 - t1;
                            s_neg = bs;
                        end
                        if (st == STAT_OK && !mul_fits(dag, bd, dn))
                            st = STAT_OVF;
                        if (st == STAT_OK) begin
                            reduce_frac(s_neg, sm, dn, r_neg, rn, rd);
                            have = 1;
                        end
                    end
                end
                MODE_MUL: begin
                    g = gcd_of(an, bd);
                    g2 = gcd_of(bn, ad);
                    if (!mul_fits(an / g, bn / g2, nn) || !mul_fits(ad / g2, bd / g, dn)) begin
                        st = STAT_OVF;
                    end else begin
                        reduce_frac(an_neg != bn_neg, nn, dn, r_neg, rn, rd);
                        have = 1;
                    end
                end
                MODE_DIV: begin
                    if (bn == 0) begin
                        st = STAT_DIVZ;
                    end else begin
                        g = gcd_of(an, bn);
                        g2 = gcd_of(ad, bd);
                        if (!mul_fits(an / g, bd / g2, nn) ||
                            !mul_fits(ad / g2, bn / g, dn)) begin
                            st = STAT_OVF;
                        end else begin
                            reduce_frac(an_neg != bn_neg, nn, dn, r_neg, rn, rd);
                            have = 1;
                        end
                    end
                end
                MODE_CMP: begin
                    if (an_neg == bn_neg && an == bn && ad == bd) begin
                        m = 0;
                    end else begin
                        sa = an == 0 ? 0 : (an_neg ? -1 : 1);
                        sb = bn == 0 ? 0 : (bn_neg ? -1 : 1);
                        if (sa != sb)
                            m = sa < sb ? -1 : 1;
                        else if (sa == 0)
                            m = 0;
                        else begin
                            m = order_pos(an, ad, bn, bd);
                            if (sa < 0)
                                m = -m;
                        end
                    end
                    ord = m < 0 ? ORD_LESS : (m == 0 ? ORD_EQUAL : ORD_GREATER);
                end
                default: begin
                    r_neg = an_neg;
                    rn = an;
                    rd = ad;
                    have = 1;
                end
            endcase
        end
        e.num = have ? (r_neg ? -rn : rn) : 64'd0;
        e.den = have ? rd[62:0] : 63'd0;
        e.order = ord;
        e.status = st;
        return e;
    endfunction

    task automatic wait_gap();
        int n;
        if ($urandom_range(0, 3) == 0)
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 4);
        else
            n = 0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic send_word(input logic [2:0] mode, input logic [63:0] an,
                             input logic [63:0] ad, input logic [63:0] bn,
                             input logic [63:0] bd);
        t_in op;
        op.mode = mode;
        op.a_num = an;
        op.a_den = ad;
        op.b_num = bn;
        op.b_den = bd;
        wait_gap();
        start <= 1'b1;
        i_op <= op;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        expected_q.push_back(rational_result(op));
        sent_count++;
        start <= 1'b0;
        i_op <= t_in'($bits(t_in)'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                    $urandom, $urandom, $urandom, $urandom}));
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_expect e;
        if (i_rst_n && o_valid) begin
            result_count++;
            if (expected_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected result word: %p", o_res);
            end else begin
                e = expected_q.pop_front();
                if (o_res.res_num !== e.num || o_res.res_den !== e.den ||
                    o_res.order !== e.order || o_res.status !== e.status) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"Mismatch: expected num %0d den %0d order %0d status %0d,",
                                  " got num %0d den %0d order %0d status %0d"},
                                 e.num, e.den, e.order, e.status, o_res.res_num,
                                 o_res.res_den, o_res.order, o_res.status);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || o_valid || (start && !busy))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
            timed_out = 1;
            $display("Watchdog expired with %0d results outstanding.", expected_q.size());
            $display("testbench failed");
            $finish;
        end
    end

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 9))
            0: return {$urandom, $urandom};
            1: return MIN_WORD;
            2: return MAG_MAX;
            3: return 64'd0;
            4, 5: return 64'($signed($urandom_range(0, 40)) - 20);
            6: return 64'($signed({$urandom, $urandom}) >>> $urandom_range(0, 63));
            default: return 64'($signed($urandom_range(0, 2000)) - 1000);
        endcase
    endfunction

    function automatic logic [63:0] rand_den();
        logic [63:0] v;
        v = rand_word();
        if ($urandom_range(0, 19) != 0 && (v == 0 || v == MIN_WORD))
            v = 64'($urandom_range(1, 100));
        return v;
    endfunction

    task automatic test_directed();
        logic [2:0] m;
        send_word(MODE_MAKE, 6, -4, 0, 0);
        send_word(MODE_MAKE, 0, -7, 0, 0);
        send_word(MODE_MAKE, 5, 0, 1, 1);
        send_word(MODE_MAKE, MIN_WORD, 1, 1, 1);
        send_word(MODE_MAKE, 1, MIN_WORD, 1, 1);
        send_word(MODE_MAKE, MAG_MAX, -MAG_MAX, 1, 1);
        send_word(MODE_ADD, 1, 2, 1, 0);
        send_word(MODE_ADD, 1, 2, MIN_WORD, 3);
        send_word(MODE_ADD, MAG_MAX, 1, 1, 1);
        send_word(MODE_SUB, -MAG_MAX, 1, 1, 1);
        send_word(MODE_SUB, 1, 3, 1, 6);
        send_word(MODE_ADD, 1, MAG_MAX, 1, MAG_MAX - 1);
        send_word(MODE_MUL, MAG_MAX, 2, 2, 3);
        send_word(MODE_MUL, MAG_MAX, 1, 2, 1);
        send_word(MODE_DIV, 3, 4, 0, 5);
        send_word(MODE_DIV, -3, 4, 9, -8);
        send_word(MODE_DIV, MAG_MAX, 1, 1, 2);
        send_word(MODE_CMP, 1, 3, 2, 6);
        send_word(MODE_CMP, -1, 3, 1, 3);
        send_word(MODE_CMP, 355, 113, 22, 7);
        send_word(MODE_CMP, -355, 113, -22, 7);
        send_word(MODE_CMP, 0, 5, 0, -3);
        m = 3'd6;
        send_word(m, 4, 8, 0, 0);
        m = 3'd7;
        send_word(m, -9, 3, 0, 0);
    endtask

    task automatic test_random();
        logic [2:0] m;
        repeat (500) begin
            m = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                             : 3'($urandom_range(0, 5));
            send_word(m, rand_word(), rand_den(), rand_word(), rand_den());
        end
    endtask

    task automatic drain();
        while (expected_q.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    initial begin
        mismatch_count = 0;
        result_count = 0;
        sent_count = 0;
        idle_cycles = 0;
        timed_out = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_op = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random();
        drain();
        $display("Sent %0d words over all modes, including operand errors, overflow,",
                 sent_count);
        $display("divide by zero and unused modes; %0d results checked.", result_count);
        if (mismatch_count == 0 && expected_q.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("Mismatches: %0d", mismatch_count);
            $display("testbench failed");
        end
        $finish;
    end

endmodule

// File: rational_arithmetic_unit.f
rtl/core/rau_pkg.sv
rtl/core/rau_divider.sv
rtl/core/rau_multiplier.sv
rtl/core/rau_datapath.sv
rtl/core/rau_ctrl.sv
rtl/core/rational_arithmetic_unit.sv
test/testbench.sv
